// ----- design/pps_pkg.sv -----
// pps_pkg: shared types and constants for the preemptive priority scheduler
// holds the queue entry layout, queue request and status structs, and result codes
// no dependencies
package pps_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic CMD_ARRIVAL = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  typedef struct packed {
    logic [7:0]  prio;
    logic [15:0] burst;
    logic [7:0]  pid;
  } entry_t;

  typedef enum logic [1:0] {
    Q_OP_INSERT,
    Q_OP_POP,
    Q_OP_PEEK
  } q_op_t;

  typedef struct packed {
    logic   valid;
    q_op_t  op;
    entry_t entry;
  } q_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [CNT_W-1:0] count;
    entry_t           head;
  } q_stat_t;

endpackage

// ----- design/preemptive_priority_scheduler.sv -----
// preemptive_priority_scheduler: tick-driven preemptive priority scheduler, top level
// holds the running process, the request sequencer and the result register
// depends on pps_pkg and pps_queue
//
// usage: each input request is an arrival (in_cmd 0) or one time tick (in_cmd 1).
// an arrival is placed in a priority-sorted ready queue behind equal priorities;
// a zero burst or a full queue drops it and reports it in out_status.
// a tick dispatches the queue head when idle, or preempts when the head is
// strictly more urgent, then runs the current process for one unit.
// every request yields exactly one result on the out_ channel.
// in_stall is high while a request is being worked on; a request is taken
// while an earlier result still waits in the output register.
// each request ends in the result stage: a dropped arrival goes there directly,
// a queued arrival after the insert, which walks the queue memory entry by entry
// from the tail (read, then compare and write), a dispatching tick after a pop,
// a tick that only checks the head after a peek, a preempting tick after a peek,
// a pop and an insert, and a tick with an empty queue after running. the next
// request is taken once the result stage has loaded the output register. the queue
// memory takes one read and one write per cycle, so those walks set the throughput.
// reset clears the queue fill, the running process and the output valid flag.
// while out_stall holds a result, the block finishes the next request and
// then waits until the output register is free.
module preemptive_priority_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_proc_id,
  input  logic [15:0] in_burst,
  input  logic [7:0]  in_prio,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_ran,
  output logic [7:0]  out_run_pid,
  output logic        out_finished,
  output logic        out_new_slice
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_WAIT,
    S_DISP_WAIT,
    S_PEEK_WAIT,
    S_PRE_POP_WAIT,
    S_PRE_INS_WAIT,
    S_EXEC,
    S_OUT
  } state_t;

  state_t           state_r;
  pps_pkg::q_req_t  q_req_r;
  pps_pkg::q_stat_t q_stat;

  pps_pkg::entry_t  run_r;
  logic             run_valid_r;
  pps_pkg::entry_t  next_r;

  logic [1:0]       res_status_r;
  logic             res_ran_r;
  logic [7:0]       res_pid_r;
  logic             res_fin_r;
  logic             res_slice_r;

  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic             out_ran_r;
  logic [7:0]       out_run_pid_r;
  logic             out_finished_r;
  logic             out_new_slice_r;

  logic             in_take;
  logic             q_full;
  logic             q_empty;

  assign in_stall = state_r != S_IDLE;
  assign in_take  = in_valid && !in_stall;
  assign q_full   = q_stat.count == pps_pkg::CNT_W'(pps_pkg::QUEUE_DEPTH);
  assign q_empty  = q_stat.count == '0;

  pps_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_req  (q_req_r),
    .q_stat (q_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      q_req_r.valid <= 1'b0;
      run_valid_r   <= 1'b0;
      run_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      q_req_r.valid <= 1'b0;
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_take) begin
            res_status_r <= pps_pkg::ST_OK;
            res_ran_r    <= 1'b0;
            res_pid_r    <= '0;
            res_fin_r    <= 1'b0;
            res_slice_r  <= 1'b0;
            if (in_cmd == pps_pkg::CMD_ARRIVAL) begin
              priority if (in_burst == '0) begin
                res_status_r <= pps_pkg::ST_ZERO;
                state_r      <= S_OUT;
              end else if (q_full) begin
                res_status_r <= pps_pkg::ST_FULL;
                state_r      <= S_OUT;
              end else begin
                q_req_r.valid       <= 1'b1;
                q_req_r.op          <= pps_pkg::Q_OP_INSERT;
                q_req_r.entry.prio  <= in_prio;
                q_req_r.entry.burst <= in_burst;
                q_req_r.entry.pid   <= in_proc_id;
                state_r             <= S_INS_WAIT;
              end
            end else begin
              priority if (q_empty) begin
                state_r <= S_EXEC;
              end else if (!run_valid_r) begin
                q_req_r.valid <= 1'b1;
                q_req_r.op    <= pps_pkg::Q_OP_POP;
                state_r       <= S_DISP_WAIT;
              end else begin
                q_req_r.valid <= 1'b1;
                q_req_r.op    <= pps_pkg::Q_OP_PEEK;
                state_r       <= S_PEEK_WAIT;
              end
            end
          end
        end
        S_INS_WAIT: begin
          if (q_stat.done) begin
            state_r <= S_OUT;
          end
        end
        S_DISP_WAIT: begin
          if (q_stat.done) begin
            run_r       <= q_stat.head;
            run_valid_r <= 1'b1;
            res_slice_r <= 1'b1;
            state_r     <= S_EXEC;
          end
        end
        S_PEEK_WAIT: begin
          if (q_stat.done) begin
            if (q_stat.head.prio < run_r.prio) begin
              q_req_r.valid <= 1'b1;
              q_req_r.op    <= pps_pkg::Q_OP_POP;
              state_r       <= S_PRE_POP_WAIT;
            end else begin
              state_r <= S_EXEC;
            end
          end
        end
        S_PRE_POP_WAIT: begin
          if (q_stat.done) begin
            next_r        <= q_stat.head;
            q_req_r.valid <= 1'b1;
            q_req_r.op    <= pps_pkg::Q_OP_INSERT;
            q_req_r.entry <= run_r;
            state_r       <= S_PRE_INS_WAIT;
          end
        end
        S_PRE_INS_WAIT: begin
          if (q_stat.done) begin
            run_r       <= next_r;
            res_slice_r <= 1'b1;
            state_r     <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (run_valid_r) begin
            res_ran_r <= 1'b1;
            res_pid_r <= run_r.pid;
            if (run_r.burst <= 16'd1) begin
              res_fin_r   <= 1'b1;
              run_valid_r <= 1'b0;
              run_r       <= '0;
            end else begin
              run_r.burst <= run_r.burst - 16'd1;
            end
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r     <= 1'b1;
            out_status_r    <= res_status_r;
            out_ran_r       <= res_ran_r;
            out_run_pid_r   <= res_pid_r;
            out_finished_r  <= res_fin_r;
            out_new_slice_r <= res_slice_r;
            state_r         <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_ran       = out_ran_r;
  assign out_run_pid   = out_run_pid_r;
  assign out_finished  = out_finished_r;
  assign out_new_slice = out_new_slice_r;

  // queue requests only go to an idle queue
  a_req_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_req_r.valid |-> !q_stat.busy)
    else $error("queue request while queue busy");

  // a running process always has work left
  a_run_burst: assert property (@(posedge clk) disable iff (!rst_n)
    run_valid_r |-> run_r.burst != '0)
    else $error("running process with zero burst");

  // a new result is only loaded from the result stage
  a_out_from_res: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result presented outside result stage");

  // queue fill stays within depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= pps_pkg::CNT_W'(pps_pkg::QUEUE_DEPTH))
    else $error("queue fill beyond depth");

endmodule

// ----- design/pps_queue.sv -----
// pps_queue: sorted ready queue in a one-read one-write memory with a step sequencer
// insert walks from the tail shifting entries up, pop shifts entries down
// depends on pps_pkg
module pps_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  pps_pkg::q_req_t  q_req,
  output pps_pkg::q_stat_t q_stat
);

  typedef enum logic [2:0] {
    Q_IDLE,
    Q_POP_RD,
    Q_POP_HEAD,
    Q_SHIFT_RD,
    Q_SHIFT_WR,
    Q_INS_RD,
    Q_INS_CMP,
    Q_INS_HEAD
  } q_state_t;

  q_state_t                      state_r;
  pps_pkg::q_op_t                op_r;
  pps_pkg::entry_t               ent_r;
  pps_pkg::entry_t               head_r;
  pps_pkg::entry_t               rd_data_r;
  logic [pps_pkg::IDX_W-1:0]     idx_r;
  logic [pps_pkg::CNT_W-1:0]     count_r;
  logic                          done_r;

  pps_pkg::entry_t               mem [pps_pkg::QUEUE_DEPTH];

  logic                          we;
  logic [pps_pkg::IDX_W-1:0]     wa;
  pps_pkg::entry_t               wd;
  logic                          ins_here;
  logic                          idx_last;

  assign ins_here = rd_data_r.prio <= ent_r.prio;
  assign idx_last = (pps_pkg::CNT_W'(idx_r) + pps_pkg::CNT_W'(1)) == count_r;

  always_comb begin
    we = 1'b0;
    wa = idx_r;
    wd = rd_data_r;
    unique case (state_r)
      Q_IDLE: begin
        if (q_req.valid && q_req.op == pps_pkg::Q_OP_INSERT &&
            count_r == '0) begin
          we = 1'b1;
          wa = '0;
          wd = q_req.entry;
        end
      end
      Q_SHIFT_WR: begin
        we = 1'b1;
        wa = idx_r - pps_pkg::IDX_W'(1);
      end
      Q_INS_CMP: begin
        we = 1'b1;
        wa = idx_r + pps_pkg::IDX_W'(1);
        wd = ins_here ? ent_r : rd_data_r;
      end
      Q_INS_HEAD: begin
        we = 1'b1;
        wa = '0;
        wd = ent_r;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= Q_IDLE;
      count_r <= '0;
      done_r  <= 1'b0;
      idx_r   <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        Q_IDLE: begin
          if (q_req.valid) begin
            op_r  <= q_req.op;
            ent_r <= q_req.entry;
            priority case (q_req.op)
              pps_pkg::Q_OP_INSERT: begin
                if (count_r == '0) begin
                  count_r <= pps_pkg::CNT_W'(1);
                  done_r  <= 1'b1;
                end else begin
                  idx_r   <= pps_pkg::IDX_W'(count_r - pps_pkg::CNT_W'(1));
                  state_r <= Q_INS_RD;
                end
              end
              pps_pkg::Q_OP_POP, pps_pkg::Q_OP_PEEK: begin
                idx_r   <= '0;
                state_r <= Q_POP_RD;
              end
              default: begin
                done_r <= 1'b1;
              end
            endcase
          end
        end
        Q_POP_RD: begin
          state_r <= Q_POP_HEAD;
        end
        Q_POP_HEAD: begin
          head_r <= rd_data_r;
          if (op_r != pps_pkg::Q_OP_POP) begin
            done_r  <= 1'b1;
            state_r <= Q_IDLE;
          end else if (count_r == pps_pkg::CNT_W'(1)) begin
            count_r <= '0;
            done_r  <= 1'b1;
            state_r <= Q_IDLE;
          end else begin
            idx_r   <= pps_pkg::IDX_W'(1);
            state_r <= Q_SHIFT_RD;
          end
        end
        Q_SHIFT_RD: begin
          state_r <= Q_SHIFT_WR;
        end
        Q_SHIFT_WR: begin
          if (idx_last) begin
            count_r <= count_r - pps_pkg::CNT_W'(1);
            done_r  <= 1'b1;
            state_r <= Q_IDLE;
          end else begin
            idx_r   <= idx_r + pps_pkg::IDX_W'(1);
            state_r <= Q_SHIFT_RD;
          end
        end
        Q_INS_RD: begin
          state_r <= Q_INS_CMP;
        end
        Q_INS_CMP: begin
          if (ins_here) begin
            count_r <= count_r + pps_pkg::CNT_W'(1);
            done_r  <= 1'b1;
            state_r <= Q_IDLE;
          end else if (idx_r == '0) begin
            state_r <= Q_INS_HEAD;
          end else begin
            idx_r   <= idx_r - pps_pkg::IDX_W'(1);
            state_r <= Q_INS_RD;
          end
        end
        Q_INS_HEAD: begin
          count_r <= count_r + pps_pkg::CNT_W'(1);
          done_r  <= 1'b1;
          state_r <= Q_IDLE;
        end
        default: begin
          state_r <= Q_IDLE;
        end
      endcase
    end
  end

  assign q_stat.busy  = state_r != Q_IDLE;
  assign q_stat.done  = done_r;
  assign q_stat.count = count_r;
  assign q_stat.head  = head_r;

  // shift steps only run over occupied entries
  a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == Q_SHIFT_WR || state_r == Q_SHIFT_RD) |->
      pps_pkg::CNT_W'(idx_r) < count_r)
    else $error("queue shift index beyond occupied entries");

  // insert never starts on a full queue
  a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == Q_IDLE && q_req.valid && q_req.op == pps_pkg::Q_OP_INSERT) |->
      count_r < pps_pkg::CNT_W'(pps_pkg::QUEUE_DEPTH))
    else $error("insert issued on full queue");

  // pop and peek need a head entry
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == Q_IDLE && q_req.valid && q_req.op != pps_pkg::Q_OP_INSERT) |->
      count_r != '0)
    else $error("pop or peek issued on empty queue");

endmodule
